@@ design/ppm_p6_stream_parser_defines.svh @@
// ----------------------------------------------------------------------------
// PPM P6 stream parser assertion macros
// Shared assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PPM_P6_STREAM_PARSER_DEFINES_SVH
`define PPM_P6_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define PPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/ppm_p6_pkg.sv @@
// ----------------------------------------------------------------------------
// PPM P6 parser package
// Request types, result codes and fixed sizes shared by the parser files.
// ----------------------------------------------------------------------------
package ppm_p6_pkg;

  localparam int unsigned SizeBits = 28;
  localparam int unsigned LimBits  = 28;
  localparam int unsigned ProdBits = 2 * SizeBits + 2;

  localparam logic [LimBits-1:0]  LimitReset = LimBits'(192000000);
  localparam logic [SizeBits-1:0] FieldMax   = {SizeBits{1'b1}};
  localparam logic [8:0]          MaxvalSat  = 9'd511;
  localparam logic [8:0]          MaxvalWant = 9'd255;
  localparam logic [7:0]          CharP      = 8'h50;
  localparam logic [7:0]          Char6      = 8'h36;

  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindPixel  = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;
  localparam logic [1:0] KindDone   = 2'd3;

  localparam logic [2:0] ErrNone   = 3'd0;
  localparam logic [2:0] ErrMagic  = 3'd1;
  localparam logic [2:0] ErrField  = 3'd2;
  localparam logic [2:0] ErrEarly  = 3'd3;
  localparam logic [2:0] ErrMaxval = 3'd4;
  localparam logic [2:0] ErrSize   = 3'd5;
  localparam logic [2:0] ErrExcess = 3'd6;
  localparam logic [2:0] ErrShort  = 3'd7;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } in_req_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          pixel_byte;
    logic [1:0]          channel;
    logic [SizeBits-1:0] image_width;
    logic [SizeBits-1:0] image_height;
    logic [2:0]          error_code;
  } out_req_t;

  typedef struct packed {
    logic               empty;
    logic               over;
    logic [LimBits-1:0] total;
  } size_status_t;

endpackage

@@ design/ppm_p6_stream_parser.sv @@
// ----------------------------------------------------------------------------
// PPM P6 stream parser
// Checks a P6 header one byte per request and passes out the pixel data.
// ----------------------------------------------------------------------------
// Input requests arrive on in_valid_i/in_ready_o with in_data_i, one file byte
// each. Every input request gives exactly one result request on
// out_valid_o/out_ready_i with out_data_o: a header byte, a pixel byte with
// its channel, image complete, or an error with its code.
// An accepted byte is held in the input register, is parsed from there into
// the result register, and is offered to the receiver from that register.
// Throughput is one byte per cycle while the receiver takes each result; the
// state update of one byte is the only loop. The image size product is
// registered from the width and height registers and is ready by the maximum
// value terminator. A stalled receiver holds the result register; the input
// register still takes one byte, then in_ready_o drops until the result is
// taken. Reset returns to waiting for the letter P with no error and the byte
// limit at 192000000. cfg_we_i/cfg_data_i write the limit; the user must write
// it only while the block is idle, which the block itself does not enforce.
// After an error every byte answers with the latched code until reset.
// ----------------------------------------------------------------------------
`include "ppm_p6_stream_parser_defines.svh"

module ppm_p6_stream_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppm_p6_pkg::LimBits-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ppm_p6_pkg::in_req_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ppm_p6_pkg::out_req_t             out_data_o
);
  import ppm_p6_pkg::*;

  localparam logic [3:0] PhP    = 4'd0;
  localparam logic [3:0] Ph6    = 4'd1;
  localparam logic [3:0] PhSep0 = 4'd2;
  localparam logic [3:0] PhPreW = 4'd3;
  localparam logic [3:0] PhW    = 4'd4;
  localparam logic [3:0] PhPreH = 4'd5;
  localparam logic [3:0] PhH    = 4'd6;
  localparam logic [3:0] PhPreM = 4'd7;
  localparam logic [3:0] PhM    = 4'd8;
  localparam logic [3:0] PhData = 4'd9;
  localparam logic [3:0] PhDone = 4'd10;
  localparam logic [3:0] PhErr  = 4'd11;

  logic                in_valid_q;
  in_req_t             in_q;
  logic                out_valid_q;
  out_req_t            out_q;
  out_req_t            res;
  logic                process;

  logic [LimBits-1:0]  limit_q;
  logic [3:0]          phase_q, phase_d;
  logic [SizeBits-1:0] width_q, width_d;
  logic [SizeBits-1:0] height_q, height_d;
  logic [8:0]          maxval_q, maxval_d;
  logic [LimBits-1:0]  total_q, total_d;
  logic [LimBits-1:0]  count_q, count_d;
  logic [1:0]          ch_q, ch_d;
  logic [2:0]          err_q, err_d;

  size_status_t        size_st;

  logic [7:0]          b;
  logic                eos, ws, dg;
  logic [3:0]          dig;
  logic [SizeBits-1:0] w_base, h_base;
  logic [SizeBits+3:0] w_mul, h_mul;
  logic [8:0]          m_base;
  logic [12:0]         m_mul;
  logic [SizeBits-1:0] w_acc, h_acc;
  logic [8:0]          m_acc;
  logic                do_fail, eos_check;
  logic [2:0]          fail_code;
  logic [1:0]          kind;
  logic [7:0]          pix;
  logic [1:0]          ch_out;

  assign process     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || process;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ppm_p6_size_check u_size_check (
    .clk_i    (clk_i),
    .width_i  (width_q),
    .height_i (height_q),
    .limit_i  (limit_q),
    .status_o (size_st)
  );

  assign b   = in_q.byte_in;
  assign eos = in_q.end_of_stream;
  assign ws  = ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  assign dg  = (b >= 8'd48) && (b <= 8'd57);
  assign dig = b[3:0];

  assign w_base = (phase_q == PhPreW) ? '0 : width_q;
  assign h_base = (phase_q == PhPreH) ? '0 : height_q;
  assign m_base = (phase_q == PhPreM) ? '0 : maxval_q;
  assign w_mul  = ({4'b0, w_base} << 3) + ({4'b0, w_base} << 1) + (SizeBits+4)'(dig);
  assign h_mul  = ({4'b0, h_base} << 3) + ({4'b0, h_base} << 1) + (SizeBits+4)'(dig);
  assign m_mul  = ({4'b0, m_base} << 3) + ({4'b0, m_base} << 1) + 13'(dig);
  assign w_acc  = (w_mul > (SizeBits+4)'(FieldMax)) ? FieldMax : w_mul[SizeBits-1:0];
  assign h_acc  = (h_mul > (SizeBits+4)'(FieldMax)) ? FieldMax : h_mul[SizeBits-1:0];
  assign m_acc  = (m_mul > 13'(MaxvalSat)) ? MaxvalSat : m_mul[8:0];

  always_comb begin
    phase_d   = phase_q;
    width_d   = width_q;
    height_d  = height_q;
    maxval_d  = maxval_q;
    total_d   = total_q;
    count_d   = count_q;
    ch_d      = ch_q;
    err_d     = err_q;
    do_fail   = 1'b0;
    fail_code = ErrNone;
    eos_check = 1'b1;
    kind      = KindHeader;
    pix       = 8'd0;
    ch_out    = 2'd0;
    unique case (phase_q) inside
      PhP: begin
        if (b != CharP) begin
          do_fail = 1'b1; fail_code = ErrMagic;
        end else begin
          phase_d = Ph6;
        end
      end
      Ph6: begin
        if (b != Char6) begin
          do_fail = 1'b1; fail_code = ErrMagic;
        end else begin
          phase_d = PhSep0;
        end
      end
      PhSep0: begin
        if (!ws) begin
          do_fail = 1'b1; fail_code = ErrField;
        end else begin
          phase_d = PhPreW;
        end
      end
      PhPreW, PhW: begin
        if (dg) begin
          width_d = w_acc; phase_d = PhW;
        end else if (ws) begin
          if (phase_q == PhW) phase_d = PhPreH;
        end else begin
          do_fail = 1'b1; fail_code = ErrField;
        end
      end
      PhPreH, PhH: begin
        if (dg) begin
          height_d = h_acc; phase_d = PhH;
        end else if (ws) begin
          if (phase_q == PhH) phase_d = PhPreM;
        end else begin
          do_fail = 1'b1; fail_code = ErrField;
        end
      end
      PhPreM: begin
        if (dg) begin
          maxval_d = m_acc; phase_d = PhM;
        end else if (!ws) begin
          do_fail = 1'b1; fail_code = ErrField;
        end
      end
      PhM: begin
        if (dg) begin
          maxval_d = m_acc;
        end else if (ws) begin
          eos_check = 1'b0;
          if (maxval_q != MaxvalWant) begin
            do_fail = 1'b1; fail_code = ErrMaxval;
          end else if (!size_st.empty && size_st.over) begin
            do_fail = 1'b1; fail_code = ErrSize;
          end else begin
            total_d = size_st.empty ? '0 : size_st.total;
            count_d = '0;
            ch_d    = 2'd0;
            if (size_st.empty) begin
              phase_d = PhDone; kind = KindDone;
            end else if (eos) begin
              do_fail = 1'b1; fail_code = ErrShort;
            end else begin
              phase_d = PhData;
            end
          end
        end else begin
          do_fail = 1'b1; fail_code = ErrField;
        end
      end
      PhData: begin
        eos_check = 1'b0;
        if (count_q >= total_q) begin
          do_fail = 1'b1; fail_code = ErrExcess;
        end else begin
          count_d = count_q + 1'b1;
          ch_d    = (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
          pix     = b;
          ch_out  = ch_q;
          if (count_d == total_q) begin
            phase_d = PhDone; kind = KindDone;
          end else if (eos) begin
            do_fail = 1'b1; fail_code = ErrShort;
          end else begin
            kind = KindPixel;
          end
        end
      end
      PhDone: begin
        do_fail = 1'b1; fail_code = ErrExcess;
      end
      default: begin
        eos_check = 1'b0;
        phase_d   = PhErr;
        kind      = KindError;
      end
    endcase
    if (eos_check && !do_fail && eos) begin
      do_fail = 1'b1; fail_code = ErrEarly;
    end
    if (do_fail) begin
      err_d   = fail_code;
      phase_d = PhErr;
      kind    = KindError;
      pix     = 8'd0;
      ch_out  = 2'd0;
    end
  end

  always_comb begin
    res.kind         = kind;
    res.pixel_byte   = pix;
    res.channel      = ch_out;
    res.image_width  = width_d;
    res.image_height = height_d;
    res.error_code   = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= LimitReset;
      phase_q     <= PhP;
      width_q     <= '0;
      height_q    <= '0;
      maxval_q    <= '0;
      total_q     <= '0;
      count_q     <= '0;
      ch_q        <= 2'd0;
      err_q       <= ErrNone;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (process) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        width_q     <= width_d;
        height_q    <= height_d;
        maxval_q    <= maxval_d;
        total_q     <= total_d;
        count_q     <= count_d;
        ch_q        <= ch_d;
        err_q       <= err_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (process) out_q <= res;
  end

  `PPM_ASSERT_NEXT(a_err_sticky, clk_i, rst_ni, phase_q == PhErr, phase_q == PhErr,
                   "error phase was left without reset")
  `PPM_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, phase_q == PhData, count_q < total_q,
                   "data count reached total while still in data phase")
  `PPM_ASSERT_IMPL(a_channel_range, clk_i, rst_ni, 1'b1, ch_q != 2'd3,
                   "channel counter out of range")
  `PPM_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !process, in_valid_q,
                   "buffered request dropped before it was parsed")

endmodule

@@ design/ppm_p6_size_check.sv @@
// ----------------------------------------------------------------------------
// PPM P6 image size check
// Registers width times height and compares three times it with the limit.
// ----------------------------------------------------------------------------
module ppm_p6_size_check (
  input  logic                              clk_i,
  input  logic [ppm_p6_pkg::SizeBits-1:0]   width_i,
  input  logic [ppm_p6_pkg::SizeBits-1:0]   height_i,
  input  logic [ppm_p6_pkg::LimBits-1:0]    limit_i,
  output ppm_p6_pkg::size_status_t          status_o
);
  import ppm_p6_pkg::*;

  logic [2*SizeBits-1:0] prod_q;
  logic [ProdBits-1:0]   prod3;

  always_ff @(posedge clk_i) begin
    prod_q <= width_i * height_i;
  end

  assign prod3 = ({2'b00, prod_q} << 1) + {2'b00, prod_q};

  assign status_o.empty = (width_i == '0) || (height_i == '0);
  assign status_o.over  = prod3 > ProdBits'(limit_i);
  assign status_o.total = prod3[LimBits-1:0];

endmodule

@@ tb/sv/tb_ppm_p6_stream_parser.sv @@
// ----------------------------------------------------------------------------
// PPM P6 stream parser testbench
// Feeds one image file stream byte by byte and compares every result request
// with a cycle-free model of the header parser, the pixel counter and the
// error latch. Since only reset clears a latched error, each run follows one
// stream: most runs carry a full image, the rest an empty image or one header
// fault. Long runs of valid bytes and random idling on both sides come first.
// The limit register is written at idle points.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ppm_p6_stream_parser;
  import ppm_p6_pkg::*;

  localparam int unsigned ClkPeriod = 20;
  localparam int unsigned ItemCount = 1500;
  localparam logic [7:0] Digit0 = 8'h30;
  localparam logic [7:0] Digit9 = 8'h39;
  localparam logic [7:0] TabChar = 8'h09;
  localparam logic [7:0] CrChar = 8'h0D;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [LimBits-1:0] LimitMin = LimBits'(3);
  localparam logic [LimBits-1:0] LimitMax = {LimBits{1'b1}};
  localparam longint unsigned HugeField = 64'd999_999_999_999;

  typedef enum logic [3:0] {
    WantP, Want6, WantSep, PreWidth, InWidth, PreHeight, InHeight,
    PreMax, InMax, InData, ImgDone, Latched
  } parse_state_e;

  typedef enum int unsigned {
    RunImage, RunMagic, RunField, RunEarlyEnd, RunMaxval, RunSize, RunEmpty,
    RunShortHeader
  } run_kind_e;

  typedef enum int unsigned {EndExcess, EndMarked, EndShort} data_end_e;
  typedef enum int unsigned {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [LimBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_req_t out_data_o;

  parse_state_e parse_state = WantP;
  logic [SizeBits-1:0] acc_width = '0;
  logic [SizeBits-1:0] acc_height = '0;
  logic [8:0] acc_maxval = '0;
  longint unsigned pixels_due = 0;
  longint unsigned pixels_seen = 0;
  logic [2:0] fault_code = ErrNone;
  logic [LimBits-1:0] byte_limit = LimitReset;

  out_req_t expected_results[$];
  in_req_t header_bytes[$];
  run_kind_e run_kind;
  data_end_e data_end;
  longint unsigned img_w, img_h, data_len, short_at;
  int unsigned bytes_sent = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned mismatches = 0;

  ppm_p6_stream_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic is_space(logic [7:0] b);
    return (b >= TabChar && b <= CrChar) || b == SpaceChar;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= Digit0 && b <= Digit9;
  endfunction

  function automatic longint unsigned add_digit(longint unsigned acc, logic [7:0] b,
                                                longint unsigned sat);
    longint unsigned v;
    v = acc * 10 + 64'(b - Digit0);
    return (v > sat) ? sat : v;
  endfunction

  function automatic out_req_t make_result(logic [1:0] kind, logic [7:0] pix,
                                           logic [1:0] ch);
    out_req_t r;
    r.kind = kind;
    r.pixel_byte = pix;
    r.channel = ch;
    r.image_width = acc_width;
    r.image_height = acc_height;
    r.error_code = fault_code;
    return r;
  endfunction

  function automatic out_req_t latch_fault(logic [2:0] code);
    fault_code = code;
    parse_state = Latched;
    return make_result(KindError, 8'h00, 2'd0);
  endfunction

  function automatic out_req_t parse_byte(in_req_t req);
    logic [7:0] b;
    logic eos, sp, dg;
    logic [1:0] ch;
    longint unsigned total;
    b = req.byte_in;
    eos = req.end_of_stream;
    sp = is_space(b);
    dg = is_digit(b);
    case (parse_state)
      WantP: begin
        if (b != CharP) return latch_fault(ErrMagic);
        parse_state = Want6;
      end
      Want6: begin
        if (b != Char6) return latch_fault(ErrMagic);
        parse_state = WantSep;
      end
      WantSep: begin
        if (!sp) return latch_fault(ErrField);
        parse_state = PreWidth;
      end
      PreWidth: begin
        if (dg) begin
          acc_width = SizeBits'(add_digit(0, b, FieldMax));
          parse_state = InWidth;
        end else if (!sp) return latch_fault(ErrField);
      end
      InWidth: begin
        if (dg) acc_width = SizeBits'(add_digit(acc_width, b, FieldMax));
        else if (sp) parse_state = PreHeight;
        else return latch_fault(ErrField);
      end
      PreHeight: begin
        if (dg) begin
          acc_height = SizeBits'(add_digit(0, b, FieldMax));
          parse_state = InHeight;
        end else if (!sp) return latch_fault(ErrField);
      end
      InHeight: begin
        if (dg) acc_height = SizeBits'(add_digit(acc_height, b, FieldMax));
        else if (sp) parse_state = PreMax;
        else return latch_fault(ErrField);
      end
      PreMax: begin
        if (dg) begin
          acc_maxval = 9'(add_digit(0, b, MaxvalSat));
          parse_state = InMax;
        end else if (!sp) return latch_fault(ErrField);
      end
      InMax: begin
        if (dg) acc_maxval = 9'(add_digit(acc_maxval, b, MaxvalSat));
        else if (!sp) return latch_fault(ErrField);
        else begin
          if (acc_maxval != MaxvalWant) return latch_fault(ErrMaxval);
          total = 64'(acc_width) * 64'(acc_height) * 64'd3;
          if (total > 64'(byte_limit)) return latch_fault(ErrSize);
          pixels_due = total;
          pixels_seen = 0;
          if (total == 0) begin
            parse_state = ImgDone;
            return make_result(KindDone, 8'h00, 2'd0);
          end
          if (eos) return latch_fault(ErrShort);
          parse_state = InData;
          return make_result(KindHeader, 8'h00, 2'd0);
        end
      end
      InData: begin
        if (pixels_seen >= pixels_due) return latch_fault(ErrExcess);
        ch = 2'(pixels_seen % 3);
        pixels_seen++;
        if (pixels_seen == pixels_due) begin
          parse_state = ImgDone;
          return make_result(KindDone, b, ch);
        end
        if (eos) return latch_fault(ErrShort);
        return make_result(KindPixel, b, ch);
      end
      ImgDone: return latch_fault(ErrExcess);
      default: return make_result(KindError, 8'h00, 2'd0);
    endcase
    if (eos) return latch_fault(ErrEarly);
    return make_result(KindHeader, 8'h00, 2'd0);
  endfunction

  function automatic idle_mode_e idle_mode();
    return idle_mode_e'((bytes_sent / 120) % 4);
  endfunction

  function automatic int unsigned send_gap_pct();
    case (idle_mode())
      IdleSender: return 82;
      IdleBoth: return 36;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned stall_pct();
    case (idle_mode())
      IdleReceiver: return 82;
      IdleBoth: return 36;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] any_space();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? SpaceChar : TabChar + 8'(k);
  endfunction

  function automatic logic [7:0] garbage_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_space(b) || is_digit(b));
    return b;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    in_req_t r;
    r.byte_in = b;
    r.end_of_stream = 1'b0;
    header_bytes.push_back(r);
  endfunction

  function automatic void put_space_run(int unsigned n);
    repeat (n) put_byte(any_space());
  endfunction

  function automatic void put_number(longint unsigned v, int unsigned zeros);
    logic [7:0] digits[$];
    repeat (zeros) put_byte(Digit0);
    do begin
      digits.push_front(Digit0 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) put_byte(digits[i]);
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(string name, longint unsigned got, longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
  endtask

  task automatic check_result(out_req_t got);
    out_req_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result request with no input pending, kind %0d", got.kind));
      return;
    end
    want = expected_results.pop_front();
    compare_field("kind", got.kind, want.kind);
    compare_field("pixel_byte", got.pixel_byte, want.pixel_byte);
    compare_field("channel", got.channel, want.channel);
    compare_field("image_width", got.image_width, want.image_width);
    compare_field("image_height", got.image_height, want.image_height);
    compare_field("error_code", got.error_code, want.error_code);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_data_o);
      if (hold_off_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct());
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eos);
    in_req_t req;
    req.byte_in = b;
    req.end_of_stream = eos;
    while ($urandom_range(0, 99) < send_gap_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(parse_byte(req));
    bytes_sent++;
  endtask

  task automatic write_limit(input logic [LimBits-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    byte_limit = value;
  endtask

  task automatic test_header_fields();
    int unsigned pad, zeros, pick, pos;
    longint unsigned maxv;
    longint unsigned bad_max[6] = '{0, 254, 256, 511, 2550, 99999};
    header_bytes = {};
    pad = (run_kind == RunImage) ? 3 : 120;
    zeros = (run_kind == RunImage) ? 2 : 40;
    pick = $urandom_range(0, 2);
    maxv = MaxvalWant;
    img_w = $urandom_range(1, 40);
    img_h = 500 / img_w + $urandom_range(0, 1);
    case (run_kind)
      RunImage: begin
        if (pick == 1) write_limit(LimBits'(img_w * img_h * 3));
        else if (pick == 2) write_limit(LimitMax);
      end
      RunMaxval: maxv = bad_max[$urandom_range(0, 5)];
      RunSize: begin
        if (pick == 0) begin
          img_w = $urandom_range(1, 50);
          img_h = $urandom_range(1, 50);
          write_limit(LimBits'(img_w * img_h * 3 - 1));
        end else if (pick == 1) begin
          img_w = 1;
          img_h = 2;
          write_limit(LimitMin);
        end else begin
          img_w = HugeField;
          img_h = HugeField;
        end
      end
      RunEmpty: begin
        img_w = (pick == 1) ? HugeField : 0;
        img_h = (pick == 0) ? $urandom_range(1, 1000) : 0;
      end
      default: ;
    endcase
    data_len = img_w * img_h * 3;

    put_byte(CharP);
    put_byte(Char6);
    if (run_kind == RunImage) begin
      for (int k = 0; k < 5; k++) put_byte(TabChar + 8'(k));
      put_byte(SpaceChar);
    end
    put_space_run($urandom_range(1, pad));
    put_number(img_w, $urandom_range(0, zeros));
    put_space_run($urandom_range(1, pad));
    put_number(img_h, $urandom_range(0, zeros));
    put_space_run($urandom_range(1, pad));
    put_number(maxv, $urandom_range(0, zeros));
    put_byte(any_space());

    case (run_kind)
      RunMagic: begin
        pos = pick % 2;
        do header_bytes[pos].byte_in = 8'($urandom_range(0, 255));
        while (header_bytes[pos].byte_in == (pos == 0 ? CharP : Char6));
      end
      RunField: begin
        pos = $urandom_range(2, header_bytes.size() - 1);
        header_bytes[pos].byte_in = (pos == 2 && pick == 0) ? Digit0 + 8'd7 : garbage_byte();
      end
      RunEarlyEnd: header_bytes[$urandom_range(0, header_bytes.size() - 2)].end_of_stream = 1'b1;
      RunEmpty: header_bytes[header_bytes.size() - 1].end_of_stream = pick[0];
      RunShortHeader: header_bytes[header_bytes.size() - 1].end_of_stream = 1'b1;
      default: ;
    endcase
    foreach (header_bytes[i]) push_byte(header_bytes[i].byte_in, header_bytes[i].end_of_stream);

    data_end = data_end_e'($urandom_range(0, 2));
    short_at = (data_len > 1) ? $urandom_range(0, data_len - 2) : 0;
  endtask

  task automatic test_pixel_stream(input longint unsigned from, input longint unsigned upto);
    longint unsigned stop;
    logic [7:0] b;
    if (run_kind != RunImage) return;
    stop = (data_end == EndShort) ? short_at + 1 : data_len;
    for (longint unsigned i = from; i < upto && i < stop; i++) begin
      if (i == 0) b = any_space();
      else if (i == 1) b = 8'h00;
      else if (i == 2) b = 8'hFF;
      else b = 8'($urandom_range(0, 255));
      if (i == from + 40) hold_off_cycles = 60;
      push_byte(b, (data_end == EndShort && i == short_at) ||
                   (data_end == EndMarked && i == data_len - 1));
    end
  endtask

  task automatic test_limit_register();
    write_limit(LimitMax);
    write_limit(LimitMin);
    write_limit(LimBits'($urandom()));
  endtask

  task automatic test_stream_end();
    hold_off_cycles = 60;
    push_byte(8'h00, 1'b1);
    repeat (23) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    while (bytes_sent < ItemCount)
      push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned r;
    r = $urandom_range(0, 15);
    run_kind = (r < 9) ? RunImage : run_kind_e'(r - 8);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_fields();
    test_pixel_stream(0, data_len / 2);
    test_limit_register();
    test_pixel_stream(data_len / 2, data_len);
    test_stream_end();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ ppm_p6_stream_parser.f @@
+incdir+design
design/ppm_p6_pkg.sv
design/ppm_p6_size_check.sv
design/ppm_p6_stream_parser.sv
tb/sv/tb_ppm_p6_stream_parser.sv
